/* hdl/deq_pkg.sv */
// Shared types, constants and codes for the double-ended queue.
package deq_pkg;

    // Store geometry; widths follow from the depth
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Action codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [2:0] ACT_PEEK_BACK  = 3'd5;
    localparam logic [2:0] ACT_SIZE       = 3'd6;
    localparam logic [2:0] ACT_CLEAR      = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DATA  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic [CNT_W-1:0]         occupancy;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic exec;   // apply the incoming word to the store
        logic load;   // move the pending result into the output register
    } t_deq_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // output register holds a word not taken this cycle
    } t_deq_sts;

endpackage

/* hdl/deq_ctrl.sv */
// Controller state machine for the double-ended queue.
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  deq_pkg::t_deq_sts i_sts,
    output deq_pkg::t_deq_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DONE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!i_sts.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/deq_dpath.sv */
// Datapath: circular store, head and count, pending result and output register.
module deq_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deq_pkg::t_in_word  i_in_word,
    input  deq_pkg::t_deq_cmd  i_cmd,
    output deq_pkg::t_deq_sts  o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_word o_out_word
);

    localparam int IDX_W  = deq_pkg::IDX_W;
    localparam int CNT_W  = deq_pkg::CNT_W;
    localparam int DATA_W = deq_pkg::DATA_W;
    localparam int DEPTH  = deq_pkg::DEPTH;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [IDX_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_count;

    // Result parked between execution and output
    logic [1:0]        r_pend_status;
    logic [1:0]        n_pend_status;
    logic [DATA_W-1:0] r_pend_imm;
    logic [DATA_W-1:0] n_pend_imm;
    logic              r_pend_mem;
    logic              n_pend_mem;
    logic [CNT_W-1:0]  r_pend_occ;

    logic                 r_out_valid;
    deq_pkg::t_out_word   r_out_word;

    logic             w_empty;
    logic             w_full;
    logic [IDX_W-1:0] w_head_dec;
    logic [IDX_W-1:0] w_head_inc;
    logic [IDX_W:0]   w_sum;
    logic [IDX_W-1:0] w_back_pos;
    logic [IDX_W-1:0] w_tail;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;

    // Index arithmetic, wrapped at the store depth
    always_comb begin
        w_empty    = (r_count == '0);
        w_full     = (r_count == CNT_W'(DEPTH));
        w_head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
        w_head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        w_sum      = (IDX_W+1)'(r_head) + (IDX_W+1)'(r_count);
        w_back_pos = (w_sum >= (IDX_W+1)'(DEPTH)) ? IDX_W'(w_sum - (IDX_W+1)'(DEPTH))
                                                  : IDX_W'(w_sum);
        w_tail     = (w_back_pos == '0) ? IDX_W'(DEPTH - 1) : w_back_pos - 1'b1;
    end

    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        n_pend_status = deq_pkg::ST_OK;
        n_pend_imm    = '0;
        n_pend_mem    = 1'b0;
        w_wr_en       = 1'b0;
        w_wr_addr     = w_back_pos;
        w_rd_en       = 1'b0;
        w_rd_addr     = r_head;
        unique case (i_in_word.action)
            deq_pkg::ACT_PUSH_FRONT: begin
                if (w_full) begin
                    n_pend_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_en   = i_cmd.exec;
                    w_wr_addr = w_head_dec;
                    n_head    = w_head_dec;
                    n_count   = r_count + 1'b1;
                end
            end
            deq_pkg::ACT_PUSH_BACK: begin
                if (w_full) begin
                    n_pend_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_en = i_cmd.exec;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_PEEK_FRONT: begin
                if (w_empty) begin
                    n_pend_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_pend_status = deq_pkg::ST_DATA;
                    n_pend_mem    = 1'b1;
                    w_rd_en       = i_cmd.exec;
                    if (i_in_word.action == deq_pkg::ACT_POP_FRONT) begin
                        n_head  = w_head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            deq_pkg::ACT_POP_BACK, deq_pkg::ACT_PEEK_BACK: begin
                if (w_empty) begin
                    n_pend_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_pend_status = deq_pkg::ST_DATA;
                    n_pend_mem    = 1'b1;
                    w_rd_en       = i_cmd.exec;
                    w_rd_addr     = w_tail;
                    if (i_in_word.action == deq_pkg::ACT_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            deq_pkg::ACT_SIZE: begin
                n_pend_status = deq_pkg::ST_DATA;
                n_pend_imm    = DATA_W'(r_count);
            end
            deq_pkg::ACT_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
        endcase
    end

    // Store: one write or one registered read per item
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_in_word.value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pend_status <= n_pend_status;
            r_pend_imm    <= n_pend_imm;
            r_pend_mem    <= n_pend_mem;
            r_pend_occ    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_word.status    <= r_pend_status;
            r_out_word.data      <= r_pend_mem ? r_rd_data : r_pend_imm;
            r_out_word.occupancy <= r_pend_occ;
        end
    end

    assign o_sts.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;

endmodule

/* hdl/double_ended_queue.sv */
// Top level of the bounded double-ended queue of signed 32-bit words.
//
// Input channel: i_in_valid / o_in_ready carry a word of action and value.
// Actions push or pop at either end, peek at either end, read the size or
// clear. Every accepted word yields exactly one result word on
// o_out_valid / i_out_ready: a status, a data value and the occupancy after
// the action. Pushing into a full store returns a full status and leaves it
// unchanged; popping or peeking an empty store returns an empty status.
// Sequence: S_IDLE takes the word and applies it to the store (single write or
// registered read of the 16-entry array); S_DONE then moves the result into the
// output register once that register is free. The controller takes no new word
// until the last result has moved into the output register.
// Stall: while the receiver holds off, the output word is held and the next
// input word is still taken and executed; it parks until the output frees.
// Reset (synchronous, active low) empties the queue and drops any pending
// result. Store contents are not cleared; only entries inside the occupied
// window are ever read.
module double_ended_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  deq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_word o_out_word
);

    deq_pkg::t_deq_cmd w_cmd;
    deq_pkg::t_deq_sts w_sts;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    deq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Occupancy never exceeds the store depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.occupancy <= deq_pkg::CNT_W'(deq_pkg::DEPTH)))
        else $error("occupancy beyond depth");

    // One word in flight: no accept directly after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accept while a word is in flight");

    // A refused push only happens with the store full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == deq_pkg::ST_FULL)
        |-> (o_out_word.occupancy == deq_pkg::CNT_W'(deq_pkg::DEPTH)))
        else $error("full status with free space");

    // An empty error carries zero data and zero occupancy
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == deq_pkg::ST_EMPTY)
        |-> (o_out_word.occupancy == '0 && o_out_word.data == '0))
        else $error("empty status with stored entries or data");

endmodule

/* bench/double_ended_queue_test.sv */
// Self-checking testbench for the bounded double-ended queue.
module double_ended_queue_test;

    localparam int DEPTH  = deq_pkg::DEPTH;
    localparam int IDX_W  = deq_pkg::IDX_W;
    localparam int CNT_W  = deq_pkg::CNT_W;
    localparam int DATA_W = deq_pkg::DATA_W;

    // Watchdog limit in clock cycles. The slowest correct run has about 2000 words, each
    // with random idle gaps at the sender and the receiver and its pass through the
    // block, plus a few long receiver hold-offs. This limit is many times that.
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    deq_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_ready;
    deq_pkg::t_out_word o_out_word;

    double_ended_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Shadow copy of the deque, kept at the block's own widths
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    logic [IDX_W-1:0]         shadow_head;
    logic [CNT_W-1:0]         shadow_count;

    // Result words still owed by the block, oldest first
    deq_pkg::t_out_word expected_results [$];

    // Both sides draw their idle cycles from 0 up to this ceiling.
    // A ceiling of zero gives a stretch with no idling at all.
    int gap_ceiling = 3;
    // Set by a test to make the receiver stall for that many cycles
    int hold_off_request = 0;

    int mismatch_count  = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int full_refusals   = 0;
    int empty_errors    = 0;
    int peak_occupancy  = 0;
    int cycle_count     = 0;

    // 12-unit clock period
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Works out the result of one word and updates the shadow deque to match.
    function automatic deq_pkg::t_out_word deque_predict(input deq_pkg::t_in_word w);
        deq_pkg::t_out_word r;
        logic [IDX_W-1:0]   tail;
        r.status    = deq_pkg::ST_OK;
        r.data      = '0;
        r.occupancy = '0;
        case (w.action)
            deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    r.status = deq_pkg::ST_FULL;
                    full_refusals++;
                end else if (w.action == deq_pkg::ACT_PUSH_FRONT) begin
                    shadow_head = IDX_W'((int'(shadow_head) + DEPTH - 1) % DEPTH);
                    shadow_store[shadow_head] = w.value;
                    shadow_count++;
                end else begin
                    tail = IDX_W'((int'(shadow_head) + int'(shadow_count)) % DEPTH);
                    shadow_store[tail] = w.value;
                    shadow_count++;
                end
            end
            deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_PEEK_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = deq_pkg::ST_EMPTY;
                    empty_errors++;
                end else begin
                    r.status = deq_pkg::ST_DATA;
                    r.data   = shadow_store[shadow_head];
                    if (w.action == deq_pkg::ACT_POP_FRONT) begin
                        shadow_head = IDX_W'((int'(shadow_head) + 1) % DEPTH);
                        shadow_count--;
                    end
                end
            end
            deq_pkg::ACT_POP_BACK, deq_pkg::ACT_PEEK_BACK: begin
                if (shadow_count == 0) begin
                    r.status = deq_pkg::ST_EMPTY;
                    empty_errors++;
                end else begin
                    r.status = deq_pkg::ST_DATA;
                    tail = IDX_W'((int'(shadow_head) + int'(shadow_count) - 1) % DEPTH);
                    r.data = shadow_store[tail];
                    if (w.action == deq_pkg::ACT_POP_BACK)
                        shadow_count--;
                end
            end
            deq_pkg::ACT_SIZE: begin
                r.status = deq_pkg::ST_DATA;
                r.data   = DATA_W'(shadow_count);
            end
            default: begin
                // clear: window emptied, stored values left behind but unreachable
                shadow_count = '0;
                shadow_head  = '0;
            end
        endcase
        r.occupancy = shadow_count;
        if (int'(shadow_count) > peak_occupancy)
            peak_occupancy = int'(shadow_count);
        return r;
    endfunction

    // Full-range random values, with the extremes and small numbers mixed in
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4:       return DATA_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    task automatic apply_reset();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        shadow_head  = '0;
        shadow_count = '0;
        foreach (shadow_store[k])
            shadow_store[k] = '0;
    endtask

    // Offers one word after a random gap and returns just after the edge that takes it.
    // Valid is only dropped when a gap follows, so it never falls and rises in one step.
    task automatic send_word(input logic [2:0] act, input logic signed [DATA_W-1:0] val);
        int                gap;
        deq_pkg::t_in_word w;
        w.action = act;
        w.value  = val;
        gap = $urandom_range(0, gap_ceiling);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_results = {expected_results, deque_predict(w)};
        words_sent++;
    endtask

    // Receiver: random ready gaps per word, plus long hold-offs on request
    initial begin
        int gap;
        int hold;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_request > 0) begin
                hold = hold_off_request;
                hold_off_request = 0;
                i_out_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            gap = $urandom_range(0, gap_ceiling);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_ready));
        end
    end

    // Result checker: every word taken at the output against the oldest expectation
    always @(posedge i_clk) begin
        deq_pkg::t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word %p", $time, o_out_word);
                mismatch_count++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                results_checked++;
                if (o_out_word.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_out_word.status);
                    mismatch_count++;
                end
                if (o_out_word.data !== want.data) begin
                    $display("%0t: data mismatch, expected %0d, got %0d",
                             $time, want.data, o_out_word.data);
                    mismatch_count++;
                end
                if (o_out_word.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy mismatch, expected %0d, got %0d",
                             $time, want.occupancy, o_out_word.occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    // Empty-deque errors, the two extremes of the value field, one at each end, clear
    task automatic test_directed();
        send_word(deq_pkg::ACT_SIZE,       pick_value());
        send_word(deq_pkg::ACT_POP_FRONT,  pick_value());
        send_word(deq_pkg::ACT_POP_BACK,   pick_value());
        send_word(deq_pkg::ACT_PEEK_FRONT, pick_value());
        send_word(deq_pkg::ACT_PEEK_BACK,  pick_value());
        send_word(deq_pkg::ACT_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
        send_word(deq_pkg::ACT_PUSH_BACK,  {1'b0, {(DATA_W-1){1'b1}}});
        send_word(deq_pkg::ACT_PUSH_FRONT, '0);
        send_word(deq_pkg::ACT_PUSH_BACK,  '1);
        send_word(deq_pkg::ACT_PEEK_FRONT, '1);
        send_word(deq_pkg::ACT_PEEK_BACK,  '0);
        send_word(deq_pkg::ACT_SIZE,       '1);
        send_word(deq_pkg::ACT_POP_BACK,   pick_value());
        send_word(deq_pkg::ACT_POP_FRONT,  pick_value());
        send_word(deq_pkg::ACT_PEEK_BACK,  pick_value());
        send_word(deq_pkg::ACT_POP_FRONT,  pick_value());
        send_word(deq_pkg::ACT_POP_BACK,   pick_value());
        send_word(deq_pkg::ACT_POP_BACK,   pick_value());
        send_word(deq_pkg::ACT_CLEAR,      pick_value());
        send_word(deq_pkg::ACT_PUSH_BACK,  32'sd5);
        send_word(deq_pkg::ACT_PUSH_FRONT, 32'sd6);
        send_word(deq_pkg::ACT_CLEAR,      '1);
        send_word(deq_pkg::ACT_PEEK_FRONT, pick_value());
        send_word(deq_pkg::ACT_SIZE,       pick_value());
    endtask

    // Fill to the brim from both ends (head wraps below zero), refuse, then drain
    task automatic test_full_and_wrap();
        send_word(deq_pkg::ACT_CLEAR, pick_value());
        for (int k = 0; k < DEPTH; k++)
            send_word((k % 2) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT,
                      pick_value());
        send_word(deq_pkg::ACT_PUSH_FRONT, pick_value());
        send_word(deq_pkg::ACT_PUSH_BACK,  pick_value());
        send_word(deq_pkg::ACT_SIZE,       pick_value());
        send_word(deq_pkg::ACT_PEEK_FRONT, pick_value());
        send_word(deq_pkg::ACT_PEEK_BACK,  pick_value());
        for (int k = 0; k < DEPTH; k++)
            send_word((k % 2) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_BACK,
                      pick_value());
        send_word(deq_pkg::ACT_POP_FRONT, pick_value());
    endtask

    // Receiver stalls for a long stretch while words keep coming back to back,
    // so the block fills its pending slot and drops o_in_ready
    task automatic test_backpressure();
        gap_ceiling = 0;
        hold_off_request = 150;
        for (int k = 0; k < 24; k++)
            send_word(deq_pkg::ACT_PUSH_BACK, pick_value());
        hold_off_request = 100;
        for (int k = 0; k < 24; k++)
            send_word(k[0] ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_PEEK_BACK,
                      pick_value());
        gap_ceiling = 3;
    endtask

    // Random words in segments. Most segments lean towards pushes or pops so the
    // occupancy sweeps between empty and full; a few are plain uniform noise.
    task automatic test_random();
        int          push_pct;
        int          r;
        logic [2:0]  act;
        for (int seg = 0; seg < 18; seg++) begin
            gap_ceiling = (seg % 4 == 2) ? 0 : 3;
            case (seg % 3)
                0:       push_pct = 75;
                1:       push_pct = 45;
                default: push_pct = 20;
            endcase
            if (seg % 6 == 5)
                hold_off_request = 60;
            for (int k = 0; k < 100; k++) begin
                r = $urandom_range(0, 99);
                if (seg % 8 == 7)
                    act = 3'($urandom_range(0, 7));
                else if (r < push_pct)
                    act = $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_BACK
                                               : deq_pkg::ACT_PUSH_FRONT;
                else if (r < push_pct + (100 - push_pct) * 6 / 10)
                    act = $urandom_range(0, 1) ? deq_pkg::ACT_POP_BACK
                                               : deq_pkg::ACT_POP_FRONT;
                else if (r < 97)
                    case ($urandom_range(0, 2))
                        0:       act = deq_pkg::ACT_PEEK_FRONT;
                        1:       act = deq_pkg::ACT_PEEK_BACK;
                        default: act = deq_pkg::ACT_SIZE;
                    endcase
                else
                    act = deq_pkg::ACT_CLEAR;
                send_word(act, pick_value());
            end
        end
        gap_ceiling = 3;
    endtask

    // Stop offering, then let every owed result come home
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        apply_reset();
        test_directed();
        test_full_and_wrap();
        test_backpressure();
        test_random();
        drain_results();
        $display("%0d words sent, %0d results checked, peak occupancy %0d of %0d",
                 words_sent, results_checked, peak_occupancy, DEPTH);
        $display("%0d full refusals, %0d empty errors, %0d mismatches",
                 full_refusals, empty_errors, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_dpath.sv
hdl/double_ended_queue.sv
bench/double_ended_queue_test.sv
